// File: hw/rtl/float_to_int8_quantizer_unit_assert.svh
// Assertion macros for the float to int8 quantizer.
`ifndef FLOAT_TO_INT8_QUANTIZER_UNIT_ASSERT_SVH
`define FLOAT_TO_INT8_QUANTIZER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// When the condition holds in a cycle, the consequence holds in that same cycle.
`define F2I8Q_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("quantizer check failed");
// When the condition holds in a cycle, the consequence holds in the next cycle.
`define F2I8Q_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("quantizer check failed");
`else
`define F2I8Q_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define F2I8Q_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: hw/rtl/f2i8q_pkg.sv
// Shared types, constants and floating-point helper functions for the quantizer.
`timescale 1ns / 1ps

package f2i8q_pkg;

    typedef struct packed {
        logic [31:0] value_bits;
        logic [31:0] scale_bits;
    } sample_t;

    typedef struct packed {
        logic signed [7:0] code;
        logic              invalid;
    } result_t;

    // Unpacked single-precision value: value = mant * 2^(exp - 23).
    // The mantissa is normalised except for subnormals, which keep exp = -126 (exp = -1 for half input).
    typedef struct packed {
        logic              sign;
        logic              nan;
        logic              inf;
        logic              zero;
        logic signed [9:0] exp;
        logic [23:0]       mant;
    } fp_t;

    typedef struct packed {
        logic              round_mode;
        logic [6:0]        upper_bound;
        logic signed [7:0] lower_bound;
        logic              input_is_half;
    } cfg_t;

    typedef enum logic [1:0] {
        REG_ROUND_MODE    = 2'd0,
        REG_UPPER_BOUND   = 2'd1,
        REG_LOWER_BOUND   = 2'd2,
        REG_INPUT_IS_HALF = 2'd3
    } cfg_reg_t;

    localparam logic              RST_ROUND_MODE    = 1'b1;
    localparam logic [6:0]        RST_UPPER_BOUND   = 7'd127;
    localparam logic signed [7:0] RST_LOWER_BOUND   = -8'sd127;
    localparam logic              RST_INPUT_IS_HALF = 1'b0;

    localparam int DIV_STAGES  = 7;
    localparam int FMUL_STAGES = 3;

    localparam logic [23:0] MANT_ONE   = 24'h800000;
    localparam logic [7:0]  CODE_LIMIT = 8'd200;

    function automatic logic [4:0] lzc24(input logic [23:0] x);
        logic [4:0] lz;
        lz = 5'd24;
        for (int i = 0; i < 24; i++) begin
            if (x[i]) begin
                lz = 5'(23 - i);
            end
        end
        return lz;
    endfunction

    function automatic logic [5:0] lzc48(input logic [47:0] x);
        logic [5:0] lz;
        lz = 6'd48;
        for (int i = 0; i < 48; i++) begin
            if (x[i]) begin
                lz = 6'(47 - i);
            end
        end
        return lz;
    endfunction

    // Rounds a normalised significand (top bit at bit 47, weight 2^e_top) to single
    // precision, nearest with ties to even, including subnormal results and overflow.
    function automatic fp_t round48(input logic sign, input logic [47:0] w,
                                    input logic signed [10:0] e_top, input logic sticky_in);
        fp_t                r;
        logic [47:0]        ws;
        logic               st;
        logic               up;
        logic [24:0]        sum;
        logic signed [10:0] dd;
        logic [5:0]         d;
        r      = '0;
        r.sign = sign;
        ws     = w;
        st     = 1'b0;
        up     = 1'b0;
        sum    = '0;
        dd     = '0;
        d      = '0;
        if (e_top > 11'sd127) begin
            r.inf = 1'b1;
        end else if (e_top >= -11'sd126) begin
            st  = (|w[22:0]) | sticky_in;
            up  = w[23] & (st | w[24]);
            sum = {1'b0, w[47:24]} + 25'(up);
            if (sum[24]) begin
                r.mant = MANT_ONE;
                if (e_top == 11'sd127) begin
                    r.inf = 1'b1;
                end else begin
                    r.exp = 10'(e_top + 11'sd1);
                end
            end else begin
                r.mant = sum[23:0];
                r.exp  = 10'(e_top);
            end
        end else begin
            dd  = -11'sd126 - e_top;
            d   = (dd > 11'sd26) ? 6'd26 : 6'(dd);
            ws  = w >> d;
            st  = sticky_in | ((w & ((48'd1 << d) - 48'd1)) != 48'd0) | (|ws[22:0]);
            up  = ws[23] & (st | ws[24]);
            sum = {1'b0, ws[47:24]} + 25'(up);
            r.mant = sum[23:0];
            r.exp  = -10'sd126;
            r.zero = (sum == 25'd0);
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/f2i8q_unpack.sv
// Input stage: splits the value and scale bit patterns into unpacked form.
`timescale 1ns / 1ps

module f2i8q_unpack (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  f2i8q_pkg::cfg_t    cfg,
    input  logic               sample_valid,
    input  f2i8q_pkg::sample_t sample,
    output logic               op_valid,
    output f2i8q_pkg::fp_t     scale_fp,
    output f2i8q_pkg::fp_t     value_fp
);
    import f2i8q_pkg::*;

    logic op_valid_reg;
    fp_t  scale_reg;
    fp_t  scale_next;
    fp_t  value_reg;
    fp_t  value_next;

    logic [7:0]  se;
    logic [22:0] sm;
    logic [4:0]  slz;
    logic [7:0]  ve;
    logic [22:0] vm;
    logic [4:0]  he;
    logic [9:0]  hm;

    // The scale divisor must be normalised, so subnormal scales are shifted up here.
    always_comb
    begin
        se  = sample.scale_bits[30:23];
        sm  = sample.scale_bits[22:0];
        slz = lzc24({1'b0, sm});
        scale_next      = '0;
        scale_next.sign = sample.scale_bits[31];
        if (se == 8'd0) begin
            scale_next.zero = (sm == 23'd0);
            scale_next.mant = {1'b0, sm} << slz;
            scale_next.exp  = -10'sd126 - $signed({5'd0, slz});
        end else if (se == 8'hFF) begin
            scale_next.nan = (sm != 23'd0);
            scale_next.inf = (sm == 23'd0);
        end else begin
            scale_next.mant = {1'b1, sm};
            scale_next.exp  = $signed({2'b00, se}) - 10'sd127;
        end
    end

    // Subnormal values stay unnormalised; the multiplier renormalises its product.
    always_comb
    begin
        ve = sample.value_bits[30:23];
        vm = sample.value_bits[22:0];
        he = sample.value_bits[14:10];
        hm = sample.value_bits[9:0];
        value_next = '0;
        if (cfg.input_is_half) begin
            value_next.sign = sample.value_bits[15];
            if (he == 5'd0) begin
                value_next.zero = (hm == 10'd0);
                value_next.mant = {14'd0, hm};
                value_next.exp  = -10'sd1;
            end else if (he == 5'h1F) begin
                value_next.nan = (hm != 10'd0);
                value_next.inf = (hm == 10'd0);
            end else begin
                value_next.mant = {1'b1, hm, 13'd0};
                value_next.exp  = $signed({5'd0, he}) - 10'sd15;
            end
        end else begin
            value_next.sign = sample.value_bits[31];
            if (ve == 8'd0) begin
                value_next.zero = (vm == 23'd0);
                value_next.mant = {1'b0, vm};
                value_next.exp  = -10'sd126;
            end else if (ve == 8'hFF) begin
                value_next.nan = (vm != 23'd0);
                value_next.inf = (vm == 23'd0);
            end else begin
                value_next.mant = {1'b1, vm};
                value_next.exp  = $signed({2'b00, ve}) - 10'sd127;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            op_valid_reg <= 1'b0;
        end else if (en) begin
            op_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            scale_reg <= scale_next;
            value_reg <= value_next;
        end
    end

    assign op_valid = op_valid_reg;
    assign scale_fp = scale_reg;
    assign value_fp = value_reg;

endmodule

// File: hw/rtl/f2i8q_recip.sv
// Pipelined restoring divider that forms the correctly rounded reciprocal of the scale.
`timescale 1ns / 1ps

module f2i8q_recip (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           op_valid,
    input  f2i8q_pkg::fp_t scale_fp,
    output logic           recip_valid,
    output f2i8q_pkg::fp_t recip_fp
);
    import f2i8q_pkg::*;

    localparam int BITS_PER_STAGE = 4;

    typedef struct packed {
        logic              sign;
        logic              nan;
        logic              inf;
        logic              zero;
        logic signed [9:0] exp;
        logic [23:0]       m;
        logic [25:0]       rem;
        logic [27:0]       quo;
    } div_t;

    div_t                  div_reg  [DIV_STAGES];
    div_t                  div_next [DIV_STAGES];
    logic [DIV_STAGES-1:0] vld_reg;
    div_t                  seed;
    div_t                  last;
    logic                  recip_valid_reg;
    fp_t                   recip_reg;
    fp_t                   recip_next;
    fp_t                   rr;
    logic [47:0]           w;
    logic signed [10:0]    ex;
    logic signed [10:0]    e_top;

    // Several quotient bits a stage; the remainder is doubled after each bit.
    function automatic div_t div_step(input div_t x);
        div_t y;
        logic ge;
        y = x;
        for (int i = 0; i < BITS_PER_STAGE; i++) begin
            ge    = (y.rem >= {2'b00, y.m});
            y.quo = {y.quo[26:0], ge};
            y.rem = (ge ? (y.rem - {2'b00, y.m}) : y.rem) << 1;
        end
        return y;
    endfunction

    // The quotient is floor(2^50 / M), so 1/scale = quotient * 2^(-27 - exp).
    always_comb
    begin
        seed      = '0;
        seed.sign = scale_fp.sign;
        seed.nan  = scale_fp.nan;
        seed.inf  = scale_fp.inf;
        seed.zero = scale_fp.zero;
        seed.exp  = scale_fp.exp;
        seed.m    = scale_fp.mant;
        seed.rem  = 26'h0800000;
        seed.quo  = '0;
        div_next[0] = div_step(seed);
        for (int k = 1; k < DIV_STAGES; k++) begin
            div_next[k] = div_step(div_reg[k-1]);
        end
    end

    always_comb
    begin
        last  = div_reg[DIV_STAGES-1];
        ex    = {last.exp[9], last.exp};
        w     = last.quo[27] ? {last.quo, 20'd0} : {last.quo[26:0], 21'd0};
        e_top = last.quo[27] ? -ex : (-ex - 11'sd1);
        rr    = round48(last.sign, w, e_top, last.rem != 26'd0);
        recip_next      = rr;
        recip_next.sign = last.sign;
        if (last.nan) begin
            recip_next.nan  = 1'b1;
            recip_next.inf  = 1'b0;
            recip_next.zero = 1'b0;
        end else if (last.zero) begin
            recip_next.inf  = 1'b1;
            recip_next.zero = 1'b0;
        end else if (last.inf) begin
            recip_next.inf  = 1'b0;
            recip_next.zero = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg         <= '0;
            recip_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg         <= {vld_reg[DIV_STAGES-2:0], op_valid};
            recip_valid_reg <= vld_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                div_reg[k] <= div_next[k];
            end
            recip_reg <= recip_next;
        end
    end

    assign recip_valid = recip_valid_reg;
    assign recip_fp    = recip_reg;

endmodule

// File: hw/rtl/f2i8q_fmul.sv
// Three-stage single-precision multiplier: product, normalise, round.
`timescale 1ns / 1ps

module f2i8q_fmul (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           a_valid,
    input  f2i8q_pkg::fp_t a,
    input  f2i8q_pkg::fp_t b,
    output logic           prod_valid,
    output f2i8q_pkg::fp_t prod
);
    import f2i8q_pkg::*;

    typedef struct packed {
        logic               sign;
        logic               nan;
        logic               inf;
        logic               zero;
        logic signed [10:0] e;
        logic [47:0]        p;
    } mul_t;

    logic [FMUL_STAGES-1:0] vld_reg;
    mul_t mul_reg;
    mul_t mul_next;
    mul_t norm_reg;
    mul_t norm_next;
    fp_t  prod_reg;
    fp_t  prod_next;
    fp_t  rr;
    logic [5:0] lz;

    always_comb
    begin
        mul_next.sign = a.sign ^ b.sign;
        mul_next.nan  = a.nan | b.nan | (a.zero & b.inf) | (a.inf & b.zero);
        mul_next.inf  = (a.inf | b.inf) & !mul_next.nan;
        mul_next.zero = (a.zero | b.zero) & !mul_next.nan;
        mul_next.e    = 11'($signed(a.exp)) + 11'($signed(b.exp)) + 11'sd1;
        mul_next.p    = a.mant * b.mant;
    end

    // Bring the leading one of the product to bit 47.
    always_comb
    begin
        lz          = lzc48(mul_reg.p);
        norm_next   = mul_reg;
        norm_next.p = mul_reg.p << lz;
        norm_next.e = mul_reg.e - $signed({5'd0, lz});
    end

    always_comb
    begin
        rr             = round48(norm_reg.sign, norm_reg.p, norm_reg.e, 1'b0);
        prod_next      = rr;
        prod_next.nan  = norm_reg.nan;
        prod_next.inf  = norm_reg.inf | (!norm_reg.nan & !norm_reg.zero & rr.inf);
        prod_next.zero = norm_reg.zero | (!norm_reg.nan & !norm_reg.inf & rr.zero);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[FMUL_STAGES-2:0], a_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            mul_reg  <= mul_next;
            norm_reg <= norm_next;
            prod_reg <= prod_next;
        end
    end

    assign prod_valid = vld_reg[FMUL_STAGES-1];
    assign prod       = prod_reg;

endmodule

// File: hw/rtl/f2i8q_toint.sv
// Rounds the scaled product to an integer and clamps it into the code range.
`timescale 1ns / 1ps

module f2i8q_toint (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  f2i8q_pkg::cfg_t    cfg,
    input  logic               q_valid,
    input  f2i8q_pkg::fp_t     q,
    output logic               result_valid,
    output f2i8q_pkg::result_t result
);
    import f2i8q_pkg::*;

    logic              rnd_valid_reg;
    logic              inv_reg;
    logic              inv_next;
    logic signed [8:0] val_reg;
    logic signed [8:0] val_next;
    logic              result_valid_reg;
    result_t           result_reg;
    result_t           result_next;
    logic [7:0]        mag;
    logic [3:0]        sh;
    logic [31:0]       y;
    logic              up;
    logic signed [8:0] hi;
    logic signed [8:0] lo;
    logic signed [8:0] c1;
    logic signed [8:0] c2;

    // Fixed point with 24 fraction bits; magnitudes are limited to 200 first.
    always_comb
    begin
        inv_next = q.nan;
        sh       = 4'(q.exp + 10'sd1);
        y        = {8'd0, q.mant} << sh;
        up       = y[23] & ((|y[22:0]) | cfg.round_mode | y[24]);
        mag      = 8'd0;
        if (q.nan || q.zero) begin
            mag = 8'd0;
        end else if (q.inf || (q.exp >= 10'sd8)) begin
            mag = CODE_LIMIT;
        end else if (q.exp < -10'sd1) begin
            mag = 8'd0;
        end else if (y[31:24] >= CODE_LIMIT) begin
            mag = CODE_LIMIT;
        end else begin
            mag = y[31:24] + 8'(up);
        end
        val_next = q.sign ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    // The lower clamp is applied last, so it wins if the bounds cross.
    always_comb
    begin
        hi = $signed({2'b00, cfg.upper_bound});
        lo = {cfg.lower_bound[7], cfg.lower_bound};
        c1 = (val_reg > hi) ? hi : val_reg;
        c2 = (c1 < lo) ? lo : c1;
        result_next.invalid = inv_reg;
        result_next.code    = inv_reg ? 8'sd0 : c2[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rnd_valid_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end else if (en) begin
            rnd_valid_reg    <= q_valid;
            result_valid_reg <= rnd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            inv_reg    <= inv_next;
            val_reg    <= val_next;
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// File: hw/rtl/float_to_int8_quantizer_unit.sv
// Depth: 17 register stages.
// Throughput: one item per cycle, sustained, bounded only by result_ready.
// The 28-bit reciprocal divider (four quotient bits a stage) sets the largest share of the depth.
// Reset (rst_n, asynchronous, active low) empties the pipeline and restores register defaults.
`timescale 1ns / 1ps
`include "float_to_int8_quantizer_unit_assert.svh"

module float_to_int8_quantizer_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_ready,
    input  f2i8q_pkg::sample_t sample,
    output logic               result_valid,
    input  logic               result_ready,
    output f2i8q_pkg::result_t result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data
);
    import f2i8q_pkg::*;

    // The value waits alongside the reciprocal and the first multiply.
    localparam int VALUE_DELAY = DIV_STAGES + 1 + FMUL_STAGES;

    logic              round_mode_reg;
    logic [6:0]        upper_bound_reg;
    logic signed [7:0] lower_bound_reg;
    logic              input_is_half_reg;
    cfg_t              cfg;

    logic en;
    logic op_valid;
    fp_t  scale_fp;
    fp_t  value_fp;
    logic recip_valid;
    fp_t  recip_fp;
    fp_t  bound_fp;
    logic p_valid;
    fp_t  p_fp;
    logic q_valid;
    fp_t  q_fp;
    fp_t  value_dly_reg [VALUE_DELAY];

    // Configuration registers. Writes are always taken; the user must make them only while
    // the pipeline is empty, so no item sees a change part way through; the block does not enforce it.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            round_mode_reg    <= RST_ROUND_MODE;
            upper_bound_reg   <= RST_UPPER_BOUND;
            lower_bound_reg   <= RST_LOWER_BOUND;
            input_is_half_reg <= RST_INPUT_IS_HALF;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_ROUND_MODE:    round_mode_reg    <= cfg_data[0];
                REG_UPPER_BOUND:   upper_bound_reg   <= cfg_data[6:0];
                REG_LOWER_BOUND:   lower_bound_reg   <= cfg_data;
                REG_INPUT_IS_HALF: input_is_half_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign cfg.round_mode    = round_mode_reg;
    assign cfg.upper_bound   = upper_bound_reg;
    assign cfg.lower_bound   = lower_bound_reg;
    assign cfg.input_is_half = input_is_half_reg;

    // The whole pipeline advances together whenever the output register is free
    // or being emptied, so a stall freezes every stage and nothing is lost.
    assign en           = !result_valid || result_ready;
    assign sample_ready = en;

    f2i8q_unpack u_unpack (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .cfg          (cfg),
        .sample_valid (sample_valid),
        .sample       (sample),
        .op_valid     (op_valid),
        .scale_fp     (scale_fp),
        .value_fp     (value_fp)
    );

    f2i8q_recip u_recip (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .op_valid    (op_valid),
        .scale_fp    (scale_fp),
        .recip_valid (recip_valid),
        .recip_fp    (recip_fp)
    );

    // The upper bound doubles as the scale multiplier; it is an exact small integer.
    always_comb
    begin
        bound_fp      = '0;
        bound_fp.zero = (upper_bound_reg == 7'd0);
        bound_fp.exp  = 10'sd23;
        bound_fp.mant = {17'd0, upper_bound_reg};
    end

    f2i8q_fmul u_mul_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .a_valid    (recip_valid),
        .a          (recip_fp),
        .b          (bound_fp),
        .prod_valid (p_valid),
        .prod       (p_fp)
    );

    always_ff @(posedge clk)
    begin
        if (en) begin
            value_dly_reg[0] <= value_fp;
            for (int k = 1; k < VALUE_DELAY; k++) begin
                value_dly_reg[k] <= value_dly_reg[k-1];
            end
        end
    end

    f2i8q_fmul u_mul_value (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .a_valid    (p_valid),
        .a          (p_fp),
        .b          (value_dly_reg[VALUE_DELAY-1]),
        .prod_valid (q_valid),
        .prod       (q_fp)
    );

    // Rounding, clamping and the output register.
    f2i8q_toint u_toint (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .cfg          (cfg),
        .q_valid      (q_valid),
        .q            (q_fp),
        .result_valid (result_valid),
        .result       (result)
    );

    // A NaN product must never leak a non-zero code.
    `F2I8Q_ASSERT_IMPLY(a_inv_zero, clk, rst_n, result_valid && result.invalid, result.code == 0)
    // While a result is held back, the pipeline must refuse new items.
    `F2I8Q_ASSERT_IMPLY(a_stall_in, clk, rst_n, result_valid && !result_ready, !sample_ready)
    // A held result stays offered in the following cycle.
    `F2I8Q_ASSERT_NEXT(a_stall_out, clk, rst_n, result_valid && !result_ready, result_valid)

endmodule
